// ----- rtl/fcfs_sm_pkg.sv -----
// Package for the FCFS scheduler: item types, microcode words and the control store.
`default_nettype none

package fcfs_sm_pkg;

  localparam int unsigned MaxJobsDef = 16;

  typedef struct packed {
    logic [15:0] job_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic        last_job;
  } job_in_t;

  typedef struct packed {
    logic [15:0] out_job_id;
    logic [15:0] out_arrival;
    logic [15:0] out_burst;
    logic [23:0] completion_time;
    logic [23:0] turnaround_time;
    logic [23:0] waiting_time;
    logic [27:0] total_waiting;
    logic        last_result;
    logic        jobs_dropped;
  } job_res_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] arr;
    logic [15:0] bur;
  } job_t;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_OUTER,
    OP_BEST,
    OP_SCAN,
    OP_RD_BEST,
    OP_HOLD,
    OP_WR_BEST,
    OP_WR_I,
    OP_INC_I,
    OP_RD_K,
    OP_DONE,
    OP_EMIT,
    OP_CLEAR
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_LAST,
    C_I_END,
    C_J_MORE,
    C_BEST_I,
    C_K_MORE
  } cond_e;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_CHECK = 4'd1;
  localparam step_t S_BEST  = 4'd2;
  localparam step_t S_SCAN  = 4'd3;
  localparam step_t S_SW_A  = 4'd4;
  localparam step_t S_SW_B  = 4'd5;
  localparam step_t S_SW_C  = 4'd6;
  localparam step_t S_SW_D  = 4'd7;
  localparam step_t S_NEXT  = 4'd8;
  localparam step_t S_RUN_A = 4'd9;
  localparam step_t S_RUN_B = 4'd10;
  localparam step_t S_RUN_C = 4'd11;
  localparam step_t S_FIN   = 4'd12;

  // taken jump goes to target, otherwise to the next step
  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } uword_t;

  function automatic uword_t ucode(step_t pc);
    uword_t w;
    unique case (pc)
      S_IDLE:  w = '{OP_LOAD,    C_NO_LAST, S_IDLE};
      S_CHECK: w = '{OP_OUTER,   C_I_END,   S_RUN_A};
      S_BEST:  w = '{OP_BEST,    C_NEVER,   S_IDLE};
      S_SCAN:  w = '{OP_SCAN,    C_J_MORE,  S_SCAN};
      S_SW_A:  w = '{OP_RD_BEST, C_BEST_I,  S_NEXT};
      S_SW_B:  w = '{OP_HOLD,    C_NEVER,   S_IDLE};
      S_SW_C:  w = '{OP_WR_BEST, C_NEVER,   S_IDLE};
      S_SW_D:  w = '{OP_WR_I,    C_NEVER,   S_IDLE};
      S_NEXT:  w = '{OP_INC_I,   C_ALWAYS,  S_CHECK};
      S_RUN_A: w = '{OP_RD_K,    C_NEVER,   S_IDLE};
      S_RUN_B: w = '{OP_DONE,    C_NEVER,   S_IDLE};
      S_RUN_C: w = '{OP_EMIT,    C_K_MORE,  S_RUN_A};
      default: w = '{OP_CLEAR,   C_ALWAYS,  S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fcfs_schedule_metrics.sv -----
// FCFS scheduler top level: job store, microcoded selection sort and schedule datapath.
//
// Jobs are taken one item per cycle while busy is low; the item with last_job set
// closes the batch and the block goes busy. Jobs beyond MAX_JOBS are dropped and
// flagged on every result of that batch. All work runs from a microcode store over
// one job memory with one read and one write port: the selection sort scans, per
// outer pass i, the remaining jobs for the earliest arrival and swaps it into
// place when needed; after the final pass check each result is read, scheduled
// and emitted in turn, and a closing step clears the batch state. Results appear
// on res_o for one cycle with res_valid_o; the receiver cannot stall them.
`default_nettype none

module fcfs_schedule_metrics #(
  parameter int unsigned MAX_JOBS = fcfs_sm_pkg::MaxJobsDef
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  output logic                  busy,
  input  fcfs_sm_pkg::job_in_t  in_i,
  output logic                  res_valid_o,
  output fcfs_sm_pkg::job_res_t res_o
);
  import fcfs_sm_pkg::*;

  localparam int unsigned IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);

  job_t          mem_q [MAX_JOBS];
  job_t          rd_q, tmp_q, cur_q;
  logic          we;
  logic [IW-1:0] wr_addr, rd_addr;
  job_t          wr_data;

  step_t         pc_q, pc_d;
  logic [CW-1:0] count_q, count_d, i_q, i_d, j_q, j_d, best_q, best_d, k_q, k_d;
  logic          ovf_q, ovf_d;
  logic [15:0]   best_arr_q, best_arr_d;
  logic [23:0]   clk_q, clk_d;
  logic [27:0]   wsum_q, wsum_d;
  job_t          tmp_d, cur_d;
  logic          valid_q, valid_d;
  job_res_t      res_q, res_d;

  uword_t        uw;
  logic          take;
  logic [CW-1:0] i_n, j_n, k_n;
  logic [23:0]   start_t, tat, wt;
  logic [24:0]   done_w;
  logic [28:0]   wsum_w;

  assign uw   = ucode(pc_q);
  assign busy = (pc_q != S_IDLE);
  assign i_n  = i_q + CW'(1);
  assign j_n  = j_q + CW'(1);
  assign k_n  = k_q + CW'(1);

  assign start_t = (clk_q > {8'd0, rd_q.arr}) ? clk_q : {8'd0, rd_q.arr};
  assign done_w  = {1'b0, start_t} + {9'd0, rd_q.bur};
  assign tat     = clk_q - {8'd0, cur_q.arr};
  assign wt      = (tat > {8'd0, cur_q.bur}) ? (tat - {8'd0, cur_q.bur}) : 24'd0;
  assign wsum_w  = {1'b0, wsum_q} + {5'd0, wt};

  always_comb begin
    unique case (uw.cond)
      C_NEVER:   take = 1'b0;
      C_ALWAYS:  take = 1'b1;
      C_NO_LAST: take = !(start && in_i.last_job);
      C_I_END:   take = (i_n >= count_q);
      C_J_MORE:  take = (j_n < count_q);
      C_BEST_I:  take = (best_q == i_q);
      C_K_MORE:  take = (k_n < count_q);
      default:   take = 1'b1;
    endcase
    pc_d = take ? uw.target : step_t'(pc_q + 4'd1);
  end

  always_comb begin
    count_d    = count_q;
    ovf_d      = ovf_q;
    i_d        = i_q;
    j_d        = j_q;
    best_d     = best_q;
    k_d        = k_q;
    best_arr_d = best_arr_q;
    clk_d      = clk_q;
    wsum_d     = wsum_q;
    tmp_d      = tmp_q;
    cur_d      = cur_q;
    valid_d    = 1'b0;
    res_d      = res_q;
    we         = 1'b0;
    wr_addr    = count_q[IW-1:0];
    wr_data    = '{id: in_i.job_id, arr: in_i.arrival_time, bur: in_i.burst_time};
    rd_addr    = i_q[IW-1:0];
    unique case (uw.op)
      OP_LOAD: begin
        if (start) begin
          if (count_q < CW'(MAX_JOBS)) begin
            we      = 1'b1;
            count_d = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      OP_OUTER: begin
        best_d  = i_q;
        j_d     = i_n;
        rd_addr = i_q[IW-1:0];
      end
      OP_BEST: begin
        best_arr_d = rd_q.arr;
        rd_addr    = j_q[IW-1:0];
      end
      OP_SCAN: begin
        if (rd_q.arr < best_arr_q) begin
          best_d     = j_q;
          best_arr_d = rd_q.arr;
        end
        j_d     = j_n;
        rd_addr = j_n[IW-1:0];
      end
      OP_RD_BEST: rd_addr = best_q[IW-1:0];
      OP_HOLD: begin
        tmp_d   = rd_q;
        rd_addr = i_q[IW-1:0];
      end
      OP_WR_BEST: begin
        we      = 1'b1;
        wr_addr = best_q[IW-1:0];
        wr_data = rd_q;
      end
      OP_WR_I: begin
        we      = 1'b1;
        wr_addr = i_q[IW-1:0];
        wr_data = tmp_q;
      end
      OP_INC_I: i_d = i_n;
      OP_RD_K: rd_addr = k_q[IW-1:0];
      OP_DONE: begin
        cur_d = rd_q;
        clk_d = done_w[24] ? 24'hFF_FFFF : done_w[23:0];
      end
      OP_EMIT: begin
        wsum_d  = wsum_w[28] ? 28'hFFF_FFFF : wsum_w[27:0];
        valid_d = 1'b1;
        res_d   = '{
          out_job_id:      cur_q.id,
          out_arrival:     cur_q.arr,
          out_burst:       cur_q.bur,
          completion_time: clk_q,
          turnaround_time: tat,
          waiting_time:    wt,
          total_waiting:   wsum_d,
          last_result:     (k_n == count_q),
          jobs_dropped:    ovf_q
        };
        k_d = k_n;
      end
      OP_CLEAR: begin
        count_d = '0;
        ovf_d   = 1'b0;
        i_d     = '0;
        k_d     = '0;
        clk_d   = '0;
        wsum_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    best_arr_q <= best_arr_d;
    tmp_q      <= tmp_d;
    cur_q      <= cur_d;
    res_q      <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= S_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      best_q  <= '0;
      k_q     <= '0;
      clk_q   <= '0;
      wsum_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
      best_q  <= best_d;
      k_q     <= k_d;
      clk_q   <= clk_d;
      wsum_q  <= wsum_d;
      valid_q <= valid_d;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  a_res_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result outside a batch");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !in_i.last_job) |=> !busy)
    else $error("went busy on a non-final item");

  a_last_ends_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_result) |=> !res_valid_o)
    else $error("result after the final one");

  a_wait_le_tat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.waiting_time <= res_o.turnaround_time))
    else $error("waiting time exceeds turnaround");

endmodule

`default_nettype wire

// ----- bench/fcfs_schedule_metrics_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the FCFS scheduler: directed and random job batches checked against a local model.
module fcfs_schedule_metrics_tb;
  import fcfs_sm_pkg::*;

  localparam int unsigned Depth = MaxJobsDef;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [31:0] ClockMax = 32'h00FF_FFFF;
  localparam logic [31:0] WaitSumMax = 32'h0FFF_FFFF;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  job_in_t  in_i = '0;
  logic     busy;
  logic     res_valid_o;
  job_res_t res_o;

  fcfs_schedule_metrics dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #2 clk_i = ~clk_i;

  job_t        job_store[Depth];
  int unsigned stored_jobs = 0;
  bit          batch_dropped = 1'b0;
  job_res_t    pending_results[$];

  int unsigned idle_pct = 0;
  int unsigned errors = 0;
  int unsigned jobs_sent = 0;
  int unsigned batches_sent = 0;
  int unsigned overflow_batches = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Store one accepted item; on the batch's last item, sort and schedule it.
  task automatic take_job(input job_in_t j);
    job_t        tmp;
    int unsigned best;
    logic [31:0] clock_now, wait_sum, at, bt, t_start, done, tat, wt;
    job_res_t    r;
    jobs_sent++;
    if (stored_jobs < Depth) begin
      job_store[stored_jobs] = '{j.job_id, j.arrival_time, j.burst_time};
      stored_jobs++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (!j.last_job) return;

    // in-place selection sort, strict less-than
    for (int unsigned i = 0; i + 1 < stored_jobs; i++) begin
      best = i;
      for (int unsigned k = i + 1; k < stored_jobs; k++)
        if (job_store[k].arr < job_store[best].arr) best = k;
      if (best != i) begin
        tmp = job_store[i];
        job_store[i] = job_store[best];
        job_store[best] = tmp;
      end
    end

    clock_now = '0;
    wait_sum = '0;
    for (int unsigned k = 0; k < stored_jobs; k++) begin
      at = {16'h0, job_store[k].arr};
      bt = {16'h0, job_store[k].bur};
      t_start = (clock_now > at) ? clock_now : at;
      done = t_start + bt;
      if (done > ClockMax) done = ClockMax;
      clock_now = done;
      tat = (done > at) ? done - at : '0;
      wt = (tat > bt) ? tat - bt : '0;
      wait_sum = wait_sum + wt;
      if (wait_sum > WaitSumMax) wait_sum = WaitSumMax;
      r.out_job_id      = job_store[k].id;
      r.out_arrival     = job_store[k].arr;
      r.out_burst       = job_store[k].bur;
      r.completion_time = done[23:0];
      r.turnaround_time = tat[23:0];
      r.waiting_time    = wt[23:0];
      r.total_waiting   = wait_sum[27:0];
      r.last_result     = (k == stored_jobs - 1);
      r.jobs_dropped    = batch_dropped;
      pending_results.push_back(r);
    end
    batches_sent++;
    if (batch_dropped) overflow_batches++;
    stored_jobs = 0;
    batch_dropped = 1'b0;
  endtask

  task automatic send_job(input job_in_t j);
    int unsigned gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= j;
    do @(posedge clk_i); while (busy);
    take_job(j);
  endtask

  task automatic check_field(input string name, input logic [27:0] want, input logic [27:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    job_res_t exp_r;
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, res_o);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("out_job_id", 28'(exp_r.out_job_id), 28'(res_o.out_job_id));
        check_field("out_arrival", 28'(exp_r.out_arrival), 28'(res_o.out_arrival));
        check_field("out_burst", 28'(exp_r.out_burst), 28'(res_o.out_burst));
        check_field("completion_time", 28'(exp_r.completion_time),
                    28'(res_o.completion_time));
        check_field("turnaround_time", 28'(exp_r.turnaround_time),
                    28'(res_o.turnaround_time));
        check_field("waiting_time", 28'(exp_r.waiting_time), 28'(res_o.waiting_time));
        check_field("total_waiting", exp_r.total_waiting, res_o.total_waiting);
        check_field("last_result", 28'(exp_r.last_result), 28'(res_o.last_result));
        check_field("jobs_dropped", 28'(exp_r.jobs_dropped), 28'(res_o.jobs_dropped));
      end
    end
  end

  task automatic test_single_extremes();
    send_job(job_in_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
    send_job(job_in_t'{16'h0000, 16'h0000, 16'h0000, 1'b1});
  endtask

  // equal arrivals out of load order, then a late arrival that leaves the CPU idle
  task automatic test_arrival_ties();
    send_job(job_in_t'{16'd1, 16'd5, 16'd2, 1'b0});
    send_job(job_in_t'{16'd2, 16'd3, 16'd4, 1'b0});
    send_job(job_in_t'{16'd3, 16'd5, 16'd1, 1'b0});
    send_job(job_in_t'{16'd4, 16'd3, 16'd0, 1'b0});
    send_job(job_in_t'{16'd5, 16'd200, 16'd7, 1'b1});
  endtask

  // seventeen items; the last one is dropped but still closes the batch
  task automatic test_capacity_overflow();
    for (int unsigned i = 0; i <= Depth; i++)
      send_job(job_in_t'{16'(16'hA000 + i), 16'(Depth - i), 16'(3 * i), i == Depth});
  endtask

  task automatic test_random_batches(input int unsigned pct, input int unsigned target);
    int unsigned n, mode, base, sent;
    job_in_t     j;
    idle_pct = pct;
    sent = 0;
    while (sent < target) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
      mode = $urandom_range(3);
      base = $urandom_range(65535);
      for (int unsigned i = 0; i < n; i++) begin
        j.job_id = 16'($urandom);
        case (mode)
          0: j.arrival_time = 16'($urandom);
          1: j.arrival_time = 16'($urandom_range(7));
          2: begin
            j.arrival_time = base[15:0];
            base = base + $urandom_range(2000);
          end
          default: j.arrival_time = base[15:0];
        endcase
        j.burst_time = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(15));
        j.last_job = (i == n - 1);
        send_job(j);
      end
      sent += n;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 9;
    test_single_extremes();
    test_arrival_ties();
    test_capacity_overflow();
    test_random_batches(9, 140);
    test_random_batches(67, 140);
    test_random_batches(0, 140);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Ran %0d jobs in %0d batches (%0d over capacity), %0d results checked.",
             jobs_sent, batches_sent, overflow_batches, results_seen);
    $display("Covered field extremes, arrival ties, idle gaps and three sender idle rates.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fcfs_sm_pkg.sv
rtl/fcfs_schedule_metrics.sv
bench/fcfs_schedule_metrics_tb.sv
